### hdl/c_subset_token_scanner_macros.svh
// Assertion helpers shared by the scanner RTL.
// Each macro takes a label, a condition and a consequence, clocked on clk
// and held off while rst_n is low.
`ifndef C_SUBSET_TOKEN_SCANNER_MACROS_SVH
`define C_SUBSET_TOKEN_SCANNER_MACROS_SVH

// Consequence must hold in the same cycle as the condition.
`define CST_ASSERT_SAME(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("scanner check failed");

// Consequence must hold in the cycle after the condition.
`define CST_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("scanner check failed");

`endif

### hdl/cst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cst_pkg;

    // Widths of positions, spans and the keyword prefix.
    localparam int POS_W    = 16;
    localparam int SPAN_W   = 16;
    localparam int KW_CHARS = 8;
    localparam int PREFIX_W = KW_CHARS * 8;
    localparam int LEN_W    = 4;
    localparam int KIND_W   = 6;
    localparam int KW_COUNT = 14;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // Scanner modes.
    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_SKIP = 3'd1;
    localparam logic [2:0] MODE_STR  = 3'd2;
    localparam logic [2:0] MODE_NUM  = 3'd3;
    localparam logic [2:0] MODE_WORD = 3'd4;
    localparam logic [2:0] MODE_STAR = 3'd5;

    // Token kinds.
    localparam logic [KIND_W-1:0] K_END     = 6'd0;
    localparam logic [KIND_W-1:0] K_ERR     = 6'd1;
    localparam logic [KIND_W-1:0] K_ID      = 6'd2;
    localparam logic [KIND_W-1:0] K_NUM     = 6'd3;
    localparam logic [KIND_W-1:0] K_STR     = 6'd4;
    localparam logic [KIND_W-1:0] K_KW_BASE = 6'd5;
    localparam logic [KIND_W-1:0] K_PLUS    = 6'd19;
    localparam logic [KIND_W-1:0] K_MINUS   = 6'd20;
    localparam logic [KIND_W-1:0] K_POW     = 6'd21;
    localparam logic [KIND_W-1:0] K_MUL     = 6'd22;
    localparam logic [KIND_W-1:0] K_DIV     = 6'd23;
    localparam logic [KIND_W-1:0] K_MOD     = 6'd24;
    localparam logic [KIND_W-1:0] K_LPAREN  = 6'd25;
    localparam logic [KIND_W-1:0] K_RPAREN  = 6'd26;
    localparam logic [KIND_W-1:0] K_LBRACE  = 6'd27;
    localparam logic [KIND_W-1:0] K_RBRACE  = 6'd28;
    localparam logic [KIND_W-1:0] K_SEMI    = 6'd29;
    localparam logic [KIND_W-1:0] K_COMMA   = 6'd30;
    localparam logic [KIND_W-1:0] K_LESS    = 6'd31;
    localparam logic [KIND_W-1:0] K_GREATER = 6'd32;
    localparam logic [KIND_W-1:0] K_ASSIGN  = 6'd33;
    localparam logic [KIND_W-1:0] K_QUEST   = 6'd34;
    localparam logic [KIND_W-1:0] K_COLON   = 6'd35;
    localparam logic [KIND_W-1:0] K_BSLASH  = 6'd36;
    localparam logic [KIND_W-1:0] K_DOT     = 6'd37;

    // Characters with a role of their own.
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_STAR    = 8'h2A;

    // Keywords, right aligned with the first character most significant.
    localparam logic [PREFIX_W-1:0] KW_TEXT [KW_COUNT] = '{
        64'h0000_7265_7475_726E,   // return
        64'h0000_0000_0000_6966,   // if
        64'h0000_0000_656C_7365,   // else
        64'h0000_0077_6869_6C65,   // while
        64'h0000_0000_0066_6F72,   // for
        64'h0000_0000_0000_646F,   // do
        64'h0000_7072_696E_7466,   // printf
        64'h0000_0000_7472_7565,   // true
        64'h0000_0066_616C_7365,   // false
        64'h756E_7369_676E_6564,   // unsigned
        64'h0000_0000_0069_6E74,   // int
        64'h0000_0066_6C6F_6174,   // float
        64'h0000_0000_6C6F_6E67,   // long
        64'h0000_0000_6175_746F    // auto
    };
    localparam logic [LEN_W-1:0] KW_LEN [KW_COUNT] = '{
        4'd6, 4'd2, 4'd4, 4'd5, 4'd3, 4'd2, 4'd6,
        4'd4, 4'd5, 4'd8, 4'd3, 4'd5, 4'd4, 4'd4
    };

    // Scanner state carried from byte to byte.
    typedef struct packed {
        logic [2:0]          mode;
        logic [POS_W-1:0]    start;
        logic [POS_W-1:0]    pos;
        logic [PREFIX_W-1:0] prefix;
        logic [LEN_W-1:0]    len;
    } scan_state_t;

    // One token result.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SPAN_W-1:0] span_start;
        logic [SPAN_W-1:0] span_end;
        logic              last;
    } token_t;

    // The tokens caused by one byte, in order.
    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } step_out_t;

    function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] p);
        return (p == POS_MAX) ? p : p + POS_W'(1);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || (c == 8'h5F);
    endfunction

    function automatic token_t make_token(input logic [KIND_W-1:0] kind,
                                          input logic [POS_W-1:0]  s,
                                          input logic [POS_W-1:0]  e);
        token_t t;
        t.kind       = kind;
        t.span_start = s[SPAN_W-1:0];
        t.span_end   = e[SPAN_W-1:0];
        t.last       = 1'b0;
        return t;
    endfunction

    // Single-character operators; anything unlisted is an error token.
    function automatic logic [KIND_W-1:0] op_kind(input logic [7:0] c);
        logic [KIND_W-1:0] k;
        case (c)
            8'h2B:   k = K_PLUS;
            8'h2D:   k = K_MINUS;
            8'h2F:   k = K_DIV;
            8'h25:   k = K_MOD;
            8'h28:   k = K_LPAREN;
            8'h29:   k = K_RPAREN;
            8'h7B:   k = K_LBRACE;
            8'h7D:   k = K_RBRACE;
            8'h3B:   k = K_SEMI;
            8'h2C:   k = K_COMMA;
            8'h3C:   k = K_LESS;
            8'h3E:   k = K_GREATER;
            8'h3D:   k = K_ASSIGN;
            8'h3F:   k = K_QUEST;
            8'h3A:   k = K_COLON;
            8'h5C:   k = K_BSLASH;
            8'h2E:   k = K_DOT;
            default: k = K_ERR;
        endcase
        return k;
    endfunction

    // Keyword lookup: the fourteen compares run side by side.
    function automatic logic [KIND_W-1:0] word_kind(input logic [PREFIX_W-1:0] prefix,
                                                    input logic [LEN_W-1:0]    len);
        logic [KIND_W-1:0] k;
        k = K_ID;
        if (len <= LEN_W'(KW_CHARS)) begin
            for (int i = 0; i < KW_COUNT; i++) begin
                if (len == KW_LEN[i] && prefix == KW_TEXT[i]) begin
                    k = K_KW_BASE + KIND_W'(i);
                end
            end
        end
        return k;
    endfunction

endpackage

`default_nettype wire

### hdl/cst_scan_step.sv
`timescale 1ns / 1ps
`default_nettype none

module cst_scan_step (
    input  wire cst_pkg::scan_state_t state,
    input  wire logic [7:0]           text_byte,
    input  wire logic                 end_of_text,
    output cst_pkg::scan_state_t      state_next,
    output cst_pkg::step_out_t        result
);
    import cst_pkg::*;

    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] pos_inc;
    token_t           tok_a;
    token_t           tok_b;
    logic [1:0]       cnt;
    logic             rescan;
    token_t           idle_tok;
    logic             idle_emit;

    // One byte of scanning: up to two tokens and the next state.
    always_comb
    begin
        pos        = state.pos;
        pos_inc    = sat_inc(pos);
        state_next = state;
        state_next.pos = pos_inc;
        tok_a      = '0;
        tok_b      = '0;
        cnt        = 2'd0;
        rescan     = 1'b0;
        idle_tok   = make_token(op_kind(text_byte), pos, pos_inc);
        idle_emit  = 1'b0;

        if (end_of_text)
        begin
            // Flush a pending token, then END; all state returns to reset.
            case (state.mode)
                MODE_STR:
                begin
                    tok_a = make_token(K_STR, state.start, pos);
                    cnt   = 2'd1;
                end
                MODE_NUM:
                begin
                    tok_a = make_token(K_NUM, state.start, pos);
                    cnt   = 2'd1;
                end
                MODE_WORD:
                begin
                    tok_a = make_token(word_kind(state.prefix, state.len), state.start, pos);
                    cnt   = 2'd1;
                end
                MODE_STAR:
                begin
                    tok_a = make_token(K_MUL, state.start, pos);
                    cnt   = 2'd1;
                end
                default:
                begin
                    cnt = 2'd0;
                end
            endcase
            if (cnt == 2'd0)
            begin
                tok_a = make_token(K_END, pos, pos);
            end
            else
            begin
                tok_b = make_token(K_END, pos, pos);
            end
            cnt        = cnt + 2'd1;
            state_next = '0;
        end
        else
        begin
            case (state.mode)
                MODE_SKIP:
                begin
                    if (text_byte == CH_NEWLINE)
                    begin
                        state_next.mode = MODE_IDLE;
                    end
                end
                MODE_STR:
                begin
                    if (text_byte == CH_QUOTE)
                    begin
                        tok_a           = make_token(K_STR, state.start, pos_inc);
                        cnt             = 2'd1;
                        state_next.mode = MODE_IDLE;
                    end
                    else if (text_byte == CH_NEWLINE)
                    begin
                        tok_a           = make_token(K_STR, state.start, pos);
                        cnt             = 2'd1;
                        state_next.mode = MODE_IDLE;
                    end
                end
                MODE_NUM:
                begin
                    if (!is_digit(text_byte))
                    begin
                        tok_a  = make_token(K_NUM, state.start, pos);
                        cnt    = 2'd1;
                        rescan = 1'b1;
                    end
                end
                MODE_WORD:
                begin
                    if (is_alpha(text_byte) || is_digit(text_byte))
                    begin
                        // Keep the first characters; the length saturates one past them.
                        if (state.len < LEN_W'(KW_CHARS))
                        begin
                            state_next.prefix = {state.prefix[PREFIX_W-9:0], text_byte};
                        end
                        if (state.len <= LEN_W'(KW_CHARS))
                        begin
                            state_next.len = state.len + LEN_W'(1);
                        end
                    end
                    else
                    begin
                        tok_a  = make_token(word_kind(state.prefix, state.len),
                                            state.start, pos);
                        cnt    = 2'd1;
                        rescan = 1'b1;
                    end
                end
                MODE_STAR:
                begin
                    if (text_byte == CH_STAR)
                    begin
                        tok_a           = make_token(K_POW, state.start, pos_inc);
                        cnt             = 2'd1;
                        state_next.mode = MODE_IDLE;
                    end
                    else
                    begin
                        tok_a  = make_token(K_MUL, state.start, pos);
                        cnt    = 2'd1;
                        rescan = 1'b1;
                    end
                end
                default:
                begin
                    rescan = 1'b1;
                end
            endcase

            // The byte that ended a token is scanned again from idle.
            if (rescan)
            begin
                state_next.mode = MODE_IDLE;
                if (is_space(text_byte))
                begin
                    state_next.mode = MODE_IDLE;
                end
                else if (text_byte == CH_HASH)
                begin
                    state_next.mode = MODE_SKIP;
                end
                else if (text_byte == CH_QUOTE)
                begin
                    state_next.mode  = MODE_STR;
                    state_next.start = pos;
                end
                else if (is_digit(text_byte))
                begin
                    state_next.mode  = MODE_NUM;
                    state_next.start = pos;
                end
                else if (is_alpha(text_byte))
                begin
                    state_next.mode   = MODE_WORD;
                    state_next.start  = pos;
                    state_next.prefix = {{(PREFIX_W-8){1'b0}}, text_byte};
                    state_next.len    = LEN_W'(1);
                end
                else if (text_byte == CH_STAR)
                begin
                    state_next.mode  = MODE_STAR;
                    state_next.start = pos;
                end
                else
                begin
                    idle_emit = 1'b1;
                end
            end

            if (idle_emit)
            begin
                if (cnt == 2'd0)
                begin
                    tok_a = idle_tok;
                end
                else
                begin
                    tok_b = idle_tok;
                end
                cnt = cnt + 2'd1;
            end
        end

        // Mark the final token caused by this byte.
        if (cnt == 2'd2)
        begin
            tok_b.last = 1'b1;
        end
        else if (cnt == 2'd1)
        begin
            tok_a.last = 1'b1;
        end

        result.count  = cnt;
        result.first  = tok_a;
        result.second = tok_b;
    end

endmodule

`default_nettype wire

### hdl/cst_token_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module cst_token_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire cst_pkg::step_out_t push_data,
    output logic                    room,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output cst_pkg::token_t         head
);
    import cst_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int FILL_W = PTR_W + 1;

    token_t             mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;
    logic [FILL_W-1:0]  push_cnt;
    logic               pop;

    // Pointer and fill bookkeeping; a step may add two tokens at once.
    always_comb
    begin
        pop         = out_valid && out_ready;
        push_cnt    = push ? FILL_W'(push_data.count) : '0;
        wr_ptr_next = wr_ptr_reg + push_cnt[PTR_W-1:0];
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        fill_next   = fill_reg + push_cnt - FILL_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Token storage.
    always_ff @(posedge clk)
    begin
        if (push && push_data.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push_data.first;
        end
        if (push && push_data.count == 2'd2)
        begin
            mem[wr_ptr_reg + PTR_W'(1)] <= push_data.second;
        end
    end

    // A step may go ahead only while two free entries remain.
    assign room      = fill_reg <= FILL_W'(DEPTH - 2);
    assign out_valid = fill_reg != '0;
    assign head      = mem[rd_ptr_reg];

endmodule

`default_nettype wire

### hdl/c_subset_token_scanner.sv
// Channel  Handshake           Payload                                      Per item
// input    in_valid/in_ready   text_byte, end_of_text                       one source byte
// output   out_valid/out_ready token_kind, span_start, span_end,            one token
//                              last_of_run
//
// A byte is taken every cycle while the token queue has two free entries.
// Output runs at one token a cycle while out_ready is high, so a byte that ends one token and starts
// another puts two tokens in the queue; the four-entry token queue absorbs it.
// The first token of a byte passes the input register and the token queue before it shows on out_valid.
// Reset clears the scanner state and the queue at once; there is no sweep.
// A stalled output only holds off input once the queue is nearly full.
`timescale 1ns / 1ps
`default_nettype none

`include "c_subset_token_scanner_macros.svh"

module c_subset_token_scanner (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] text_byte,
    input  wire logic       end_of_text,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [5:0]      token_kind,
    output logic [15:0]     span_start,
    output logic [15:0]     span_end,
    output logic            last_of_run
);
    import cst_pkg::*;

    logic        hold_vld_reg;
    logic        hold_vld_next;
    logic [7:0]  hold_byte_reg;
    logic        hold_eot_reg;
    logic        step_go;
    logic        fifo_room;
    scan_state_t state_reg;
    scan_state_t state_next;
    step_out_t   step;
    token_t      head;

    // Input register: refills in the same cycle it is stepped.
    assign step_go       = hold_vld_reg && fifo_room;
    assign in_ready      = !hold_vld_reg || step_go;
    assign hold_vld_next = in_ready ? in_valid : hold_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_vld_reg <= 1'b0;
        end
        else
        begin
            hold_vld_reg <= hold_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            hold_byte_reg <= text_byte;
            hold_eot_reg  <= end_of_text;
        end
    end

    // Scanner state advances once per stepped byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (step_go)
        begin
            state_reg <= state_next;
        end
    end

    cst_scan_step u_step (
        .state       (state_reg),
        .text_byte   (hold_byte_reg),
        .end_of_text (hold_eot_reg),
        .state_next  (state_next),
        .result      (step)
    );

    cst_token_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step_go),
        .push_data (step),
        .room      (fifo_room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    // Output fields.
    assign token_kind  = head.kind;
    assign span_start  = head.span_start;
    assign span_end    = head.span_end;
    assign last_of_run = head.last;

    // An end of text always yields at least the END token.
    `CST_ASSERT_SAME(a_eot_emits, step_go && hold_eot_reg, step.count != 2'd0)

    // After end of text the scanner is back at its reset state.
    `CST_ASSERT_NEXT(a_eot_rewinds, step_go && hold_eot_reg,
                     state_reg.mode == MODE_IDLE && state_reg.pos == '0)

    // The position never moves backward on an ordinary byte.
    `CST_ASSERT_NEXT(a_pos_grows, step_go && !hold_eot_reg,
                     state_reg.pos >= $past(state_reg.pos))

endmodule

`default_nettype wire

### dv/c_subset_token_scanner_test.sv
`timescale 1ns / 1ps

module c_subset_token_scanner_test;

    import cst_pkg::*;

    // Handshake pacing used while a stretch of text is in flight.
    typedef enum int {
        PACE_FULL,
        PACE_SENDER_IDLE,
        PACE_RECEIVER_STALL,
        PACE_BOTH
    } pace_t;

    // One source byte waiting to be offered to the scanner.
    typedef struct {
        logic [7:0] ch;
        logic       eot;
        pace_t      pace;
    } text_item_t;

    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 16;
    localparam int RANDOM_BYTES = 1650;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  text_byte = 8'd0;
    logic        end_of_text = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [5:0]  token_kind;
    logic [15:0] span_start;
    logic [15:0] span_end;
    logic        last_of_run;

    // Byte stream still to be sent and tokens still to be seen.
    text_item_t pending_items [$];
    token_t     expected_tokens [$];
    text_item_t next_item;
    token_t     oldest_token;
    pace_t      fill_pace = PACE_FULL;
    pace_t      active_pace = PACE_FULL;
    int         error_count = 0;
    int unsigned quiet_cycles = 0;

    // Scanner state as the testbench tracks it.
    logic [2:0]          scan_mode = MODE_IDLE;
    logic [POS_W-1:0]    scan_start = '0;
    logic [POS_W-1:0]    scan_pos = '0;
    logic [PREFIX_W-1:0] scan_prefix = '0;
    logic [LEN_W-1:0]    scan_len = '0;

    string keyword_text [KW_COUNT] = '{
        "return", "if", "else", "while", "for", "do", "printf",
        "true", "false", "unsigned", "int", "float", "long", "auto"
    };
    string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    string op_chars = "+-/%(){};,<>=?:\\.*";

    c_subset_token_scanner uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .token_kind  (token_kind),
        .span_start  (span_start),
        .span_end    (span_end),
        .last_of_run (last_of_run)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Character classes and token lookup.
    function automatic logic [POS_W-1:0] step_pos(input logic [POS_W-1:0] p);
        return (p == POS_MAX) ? p : p + POS_W'(1);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_word_start(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c == "_");
    endfunction

    function automatic token_t span_token(input logic [KIND_W-1:0] kind,
                                          input logic [POS_W-1:0]  s,
                                          input logic [POS_W-1:0]  e);
        token_t t;
        t.kind       = kind;
        t.span_start = s[SPAN_W-1:0];
        t.span_end   = e[SPAN_W-1:0];
        t.last       = 1'b0;
        return t;
    endfunction

    function automatic logic [KIND_W-1:0] op_token(input logic [7:0] c);
        case (c)
            "+":     return K_PLUS;
            "-":     return K_MINUS;
            "/":     return K_DIV;
            "%":     return K_MOD;
            "(":     return K_LPAREN;
            ")":     return K_RPAREN;
            "{":     return K_LBRACE;
            "}":     return K_RBRACE;
            ";":     return K_SEMI;
            ",":     return K_COMMA;
            "<":     return K_LESS;
            ">":     return K_GREATER;
            "=":     return K_ASSIGN;
            "?":     return K_QUEST;
            ":":     return K_COLON;
            "\\":    return K_BSLASH;
            ".":     return K_DOT;
            default: return K_ERR;
        endcase
    endfunction

    // Words longer than the prefix can never be keywords.
    function automatic logic [KIND_W-1:0] keyword_or_id(input logic [PREFIX_W-1:0] prefix,
                                                        input logic [LEN_W-1:0]    len);
        logic [PREFIX_W-1:0] packed_kw;
        string s;
        if (len > LEN_W'(KW_CHARS))
            return K_ID;
        for (int i = 0; i < KW_COUNT; i++)
        begin
            s = keyword_text[i];
            packed_kw = '0;
            for (int j = 0; j < s.len(); j++)
                packed_kw = {packed_kw[PREFIX_W-9:0], s[j]};
            if (s.len() == len && packed_kw == prefix)
                return K_KW_BASE + KIND_W'(i);
        end
        return K_ID;
    endfunction

    // Advance the tracked scanner by one accepted item and queue its tokens.
    task automatic scan_item(input logic [7:0] ch, input logic eot);
        token_t run [$];
        logic [POS_W-1:0] pos;
        logic rescan;
        pos = scan_pos;
        rescan = 1'b0;
        if (eot)
        begin
            case (scan_mode)
                MODE_STR:  run.push_back(span_token(K_STR, scan_start, pos));
                MODE_NUM:  run.push_back(span_token(K_NUM, scan_start, pos));
                MODE_WORD: run.push_back(span_token(keyword_or_id(scan_prefix, scan_len),
                                                    scan_start, pos));
                MODE_STAR: run.push_back(span_token(K_MUL, scan_start, pos));
                default:   ;
            endcase
            run.push_back(span_token(K_END, pos, pos));
            scan_mode   = MODE_IDLE;
            scan_start  = '0;
            scan_pos    = '0;
            scan_prefix = '0;
            scan_len    = '0;
        end
        else
        begin
            case (scan_mode)
                MODE_SKIP:
                begin
                    if (ch == CH_NEWLINE)
                        scan_mode = MODE_IDLE;
                end
                MODE_STR:
                begin
                    if (ch == CH_QUOTE)
                    begin
                        run.push_back(span_token(K_STR, scan_start, step_pos(pos)));
                        scan_mode = MODE_IDLE;
                    end
                    else if (ch == CH_NEWLINE)
                    begin
                        run.push_back(span_token(K_STR, scan_start, pos));
                        scan_mode = MODE_IDLE;
                    end
                end
                MODE_NUM:
                begin
                    if (!is_numeral(ch))
                    begin
                        run.push_back(span_token(K_NUM, scan_start, pos));
                        rescan = 1'b1;
                    end
                end
                MODE_WORD:
                begin
                    if (is_word_start(ch) || is_numeral(ch))
                    begin
                        if (scan_len < LEN_W'(KW_CHARS))
                            scan_prefix = {scan_prefix[PREFIX_W-9:0], ch};
                        if (scan_len <= LEN_W'(KW_CHARS))
                            scan_len = scan_len + LEN_W'(1);
                    end
                    else
                    begin
                        run.push_back(span_token(keyword_or_id(scan_prefix, scan_len),
                                                 scan_start, pos));
                        rescan = 1'b1;
                    end
                end
                MODE_STAR:
                begin
                    if (ch == CH_STAR)
                    begin
                        run.push_back(span_token(K_POW, scan_start, step_pos(pos)));
                        scan_mode = MODE_IDLE;
                    end
                    else
                    begin
                        run.push_back(span_token(K_MUL, scan_start, pos));
                        rescan = 1'b1;
                    end
                end
                default: rescan = 1'b1;
            endcase

            // The byte that ended a token, or any byte in idle, starts afresh.
            if (rescan)
            begin
                scan_mode = MODE_IDLE;
                if (ch == CH_HASH)
                    scan_mode = MODE_SKIP;
                else if (ch == CH_QUOTE || is_numeral(ch) || ch == CH_STAR)
                begin
                    scan_mode  = (ch == CH_QUOTE) ? MODE_STR :
                                 (ch == CH_STAR) ? MODE_STAR : MODE_NUM;
                    scan_start = pos;
                end
                else if (is_word_start(ch))
                begin
                    scan_mode   = MODE_WORD;
                    scan_start  = pos;
                    scan_prefix = {{(PREFIX_W-8){1'b0}}, ch};
                    scan_len    = LEN_W'(1);
                end
                else if (!is_blank(ch))
                    run.push_back(span_token(op_token(ch), pos, step_pos(pos)));
            end
            scan_pos = step_pos(pos);
        end

        if (run.size() > 0)
            run[run.size()-1].last = 1'b1;
        foreach (run[i])
            expected_tokens.push_back(run[i]);
    endtask

    task automatic report_mismatch(input string what);
        if (error_count < 100)
            $display("MISMATCH at %0t ns: %s", $realtime, what);
        error_count++;
    endtask

    function automatic logic sender_rests(input pace_t pace);
        if (pace == PACE_SENDER_IDLE)
            return $urandom_range(0, 99) < 70;
        if (pace == PACE_BOTH)
            return $urandom_range(0, 99) < 23;
        return 1'b0;
    endfunction

    function automatic logic receiver_stalls(input pace_t pace);
        if (pace == PACE_RECEIVER_STALL)
            return $urandom_range(0, 99) < 70;
        if (pace == PACE_BOTH)
            return $urandom_range(0, 99) < 23;
        return 1'b0;
    endfunction

    // Building the byte stream.
    task automatic put_byte(input logic [7:0] ch);
        text_item_t it;
        it.ch   = ch;
        it.eot  = 1'b0;
        it.pace = fill_pace;
        pending_items.push_back(it);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endtask

    // The byte beside the end flag is random, since the scanner ignores it.
    task automatic put_end();
        text_item_t it;
        it.ch   = 8'($urandom_range(0, 255));
        it.eot  = 1'b1;
        it.pace = fill_pace;
        pending_items.push_back(it);
    endtask

    function automatic logic [7:0] blank_byte();
        int unsigned k;
        k = $urandom_range(0, 5);
        return (k == 5) ? 8'd32 : 8'(9 + k);
    endfunction

    task automatic put_comment();
        logic [7:0] c;
        put_byte(CH_HASH);
        repeat ($urandom_range(0, 12))
        begin
            c = 8'($urandom_range(0, 255));
            put_byte((c == CH_NEWLINE) ? 8'd32 : c);
        end
        put_byte(CH_NEWLINE);
    endtask

    // One token of mostly well-formed source, with some noise mixed in.
    task automatic put_random_token();
        int unsigned pick;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 18)
        begin
            put_text(keyword_text[$urandom_range(0, KW_COUNT-1)]);
            if ($urandom_range(0, 4) == 0)
                put_byte(word_chars[$urandom_range(0, word_chars.len()-1)]);
        end
        else if (pick < 34)
        begin
            put_byte(word_chars[$urandom_range(0, 52)]);
            repeat ($urandom_range(0, 11))
                put_byte(word_chars[$urandom_range(0, word_chars.len()-1)]);
        end
        else if (pick < 46)
        begin
            repeat ($urandom_range(1, 6))
                put_byte(8'("0" + $urandom_range(0, 9)));
        end
        else if (pick < 54)
        begin
            put_byte(CH_QUOTE);
            repeat ($urandom_range(0, 10))
            begin
                c = 8'($urandom_range(32, 126));
                put_byte((c == CH_QUOTE) ? "a" : c);
            end
            case ($urandom_range(0, 3))
                0:       put_byte(CH_NEWLINE);
                1:       ;
                default: put_byte(CH_QUOTE);
            endcase
        end
        else if (pick < 70)
            put_byte(op_chars[$urandom_range(0, op_chars.len()-1)]);
        else if (pick < 74)
            put_text("**");
        else if (pick < 82)
            put_comment();
        else if (pick < 94)
        begin
            repeat ($urandom_range(1, 3))
                put_byte(blank_byte());
        end
        else
            put_byte(8'($urandom_range(0, 255)));
    endtask

    // Driver: offers queued bytes and predicts on every accepted one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            text_byte   <= 8'd0;
            end_of_text <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                scan_item(text_byte, end_of_text);
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() != 0 && !sender_rests(pending_items[0].pace))
                begin
                    next_item = pending_items.pop_front();
                    in_valid    <= 1'b1;
                    text_byte   <= next_item.ch;
                    end_of_text <= next_item.eot;
                    active_pace <= next_item.pace;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each accepted token against the oldest expected one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_tokens.size() == 0)
                    report_mismatch($sformatf("unexpected token kind %0d span %0d..%0d",
                                              token_kind, span_start, span_end));
                else
                begin
                    oldest_token = expected_tokens.pop_front();
                    if (token_kind !== oldest_token.kind)
                        report_mismatch($sformatf("token_kind %0d, expected %0d",
                                                  token_kind, oldest_token.kind));
                    if (span_start !== oldest_token.span_start)
                        report_mismatch($sformatf("span_start %0d, expected %0d",
                                                  span_start, oldest_token.span_start));
                    if (span_end !== oldest_token.span_end)
                        report_mismatch($sformatf("span_end %0d, expected %0d",
                                                  span_end, oldest_token.span_end));
                    if (last_of_run !== oldest_token.last)
                        report_mismatch($sformatf("last_of_run %0b, expected %0b",
                                                  last_of_run, oldest_token.last));
                end
            end
            out_ready <= !receiver_stalls(active_pace);
        end
    end

    // Watchdog: ends the run once both channels have been quiet too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned doc;
        int unsigned mark;

        // Directed: each scanning path, and end of input in string, number, star and comment modes.
        fill_pace = PACE_FULL;
        put_text("#a\n");
        put_text("\"x\"");
        put_text("\"\n");
        put_text("9**");
        put_text("*_ do(");
        put_byte(8'hFF);
        put_byte(8'h00);
        put_byte(CH_QUOTE);
        put_end();
        put_byte("1");
        put_end();
        put_byte(CH_STAR);
        put_end();
        put_byte(CH_HASH);
        put_end();

        // Random source texts, each closed by the end flag, pacing in rotation.
        mark = pending_items.size();
        doc = 0;
        while (pending_items.size() < mark + RANDOM_BYTES)
        begin
            fill_pace = pace_t'(doc % 4);
            if ($urandom_range(0, 19) == 0)
            begin
                repeat ($urandom_range(1, 20))
                    put_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                repeat ($urandom_range(1, 30))
                begin
                    put_random_token();
                    if ($urandom_range(0, 9) < 6)
                        put_byte(blank_byte());
                end
            end
            if ($urandom_range(0, 9) == 0)
                put_end();
            put_end();
            doc++;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (!(pending_items.size() == 0 && !in_valid && expected_tokens.size() == 0))
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
